// ===== sv/e2q_pkg.sv =====
package e2q_pkg;

  localparam int CORDIC_STEPS = 28;
  localparam int XY_W         = 34;   // CORDIC x/y datapath, Q2.30 plus guard
  localparam int Z_W          = 32;   // angle residue, 2^-28 rad
  localparam int TRIG_W       = 32;   // cos/sin handed to the merge stage
  localparam int PAIR_W       = 33;   // floored pair product, Q30
  localparam int TERM_W       = 65;   // triple product, Q60
  localparam int SUM_W        = 66;
  localparam int ANGLE_W      = 16;
  localparam int QUAT_W       = 16;

  localparam int LANE_LAT     = CORDIC_STEPS + 1;
  localparam int MERGE_LAT    = 3;
  localparam int TOTAL_LAT    = LANE_LAT + MERGE_LAT;

  localparam logic signed [Z_W-1:0]  HALF_PI_Z   = 32'sd421657428;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

  function automatic logic signed [Z_W-1:0] atan_lut(input int idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      0: v = 32'sd210828714;
      1: v = 32'sd124459457;
      2: v = 32'sd65760959;
      3: v = 32'sd33381290;
      4: v = 32'sd16755422;
      5: v = 32'sd8385879;
      6: v = 32'sd4193963;
      7: v = 32'sd2097109;
      8: v = 32'sd1048571;
      9: v = 32'sd524287;
      // small angles: atan(2^-i) rounds to 2^(28-i)
      default: v = Z_W'(signed'(32'sd1) <<< (28 - idx));
    endcase
    return v;
  endfunction

endpackage

// ===== sv/e2q_cordic_lane.sv =====
module e2q_cordic_lane (
  input  logic                                clk,
  input  logic signed [e2q_pkg::ANGLE_W-1:0]  angle,
  output logic signed [e2q_pkg::TRIG_W-1:0]   cos_half,
  output logic signed [e2q_pkg::TRIG_W-1:0]   sin_half
);
  import e2q_pkg::*;

  logic signed [XY_W-1:0] x_r [0:CORDIC_STEPS];
  logic signed [XY_W-1:0] y_r [0:CORDIC_STEPS];
  logic signed [Z_W-1:0]  z_r [0:CORDIC_STEPS];

  logic signed [Z_W-1:0]  z0;
  logic signed [XY_W-1:0] x_nxt, y_nxt;
  logic signed [Z_W-1:0]  z_nxt;

  // half angle: Q3.13 word read as Q2.14, scaled to 2^-28 rad
  assign z0 = Z_W'(angle) <<< 14;

  // quadrant pre-rotation
  always_comb begin
    x_nxt = CORDIC_GAIN;
    y_nxt = '0;
    z_nxt = z0;
    if (z0 > HALF_PI_Z) begin
      x_nxt = '0;
      y_nxt = CORDIC_GAIN;
      z_nxt = z0 - HALF_PI_Z;
    end else if (z0 < -HALF_PI_Z) begin
      x_nxt = '0;
      y_nxt = -CORDIC_GAIN;
      z_nxt = z0 + HALF_PI_Z;
    end
  end

  always_ff @(posedge clk) begin
    x_r[0] <= x_nxt;
    y_r[0] <= y_nxt;
    z_r[0] <= z_nxt;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (z_r[i] >= 0) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - atan_lut(i);
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + atan_lut(i);
      end
    end
  end

  assign cos_half = x_r[CORDIC_STEPS][TRIG_W-1:0];
  assign sin_half = y_r[CORDIC_STEPS][TRIG_W-1:0];

endmodule

// ===== sv/e2q_merge.sv =====
module e2q_merge (
  input  logic                               clk,
  input  logic signed [e2q_pkg::TRIG_W-1:0]  cy,
  input  logic signed [e2q_pkg::TRIG_W-1:0]  sy,
  input  logic signed [e2q_pkg::TRIG_W-1:0]  cp,
  input  logic signed [e2q_pkg::TRIG_W-1:0]  sp,
  input  logic signed [e2q_pkg::TRIG_W-1:0]  cr,
  input  logic signed [e2q_pkg::TRIG_W-1:0]  sr,
  output logic signed [e2q_pkg::QUAT_W-1:0]  qx,
  output logic signed [e2q_pkg::QUAT_W-1:0]  qy,
  output logic signed [e2q_pkg::QUAT_W-1:0]  qz,
  output logic signed [e2q_pkg::QUAT_W-1:0]  qw
);
  import e2q_pkg::*;

  localparam int RND_SH = 45;
  localparam int Q_W    = SUM_W - RND_SH;

  function automatic logic signed [QUAT_W-1:0] to_q15(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] r;
    logic signed [Q_W-1:0]   q;
    r = s + (SUM_W'(1) <<< (RND_SH - 1));
    q = Q_W'(r >>> RND_SH);
    if (q > Q_W'(32767))       return 16'sh7fff;
    else if (q < -Q_W'(32768)) return 16'sh8000;
    else                       return q[QUAT_W-1:0];
  endfunction

  logic signed [2*TRIG_W-1:0] m_cc, m_ss, m_cs, m_sc;
  logic signed [PAIR_W-1:0]   pcc_r, pss_r, pcs_r, psc_r;
  logic signed [TRIG_W-1:0]   cy_r, sy_r;
  logic signed [TERM_W-1:0]   t_ccs_r, t_ssc_r, t_csc_r, t_scs_r;
  logic signed [TERM_W-1:0]   t_scc_r, t_css_r, t_ccc_r, t_sss_r;

  // stage 1: roll x pitch pairs, floored to Q30
  assign m_cc = cr * cp;
  assign m_ss = sr * sp;
  assign m_cs = cr * sp;
  assign m_sc = sr * cp;

  always_ff @(posedge clk) begin
    pcc_r <= m_cc[PAIR_W+29:30];
    pss_r <= m_ss[PAIR_W+29:30];
    pcs_r <= m_cs[PAIR_W+29:30];
    psc_r <= m_sc[PAIR_W+29:30];
    cy_r  <= cy;
    sy_r  <= sy;
  end

  // stage 2: times yaw terms, Q60
  always_ff @(posedge clk) begin
    t_ccs_r <= TERM_W'(pcc_r) * TERM_W'(sy_r);
    t_ssc_r <= TERM_W'(pss_r) * TERM_W'(cy_r);
    t_csc_r <= TERM_W'(pcs_r) * TERM_W'(cy_r);
    t_scs_r <= TERM_W'(psc_r) * TERM_W'(sy_r);
    t_scc_r <= TERM_W'(psc_r) * TERM_W'(cy_r);
    t_css_r <= TERM_W'(pcs_r) * TERM_W'(sy_r);
    t_ccc_r <= TERM_W'(pcc_r) * TERM_W'(cy_r);
    t_sss_r <= TERM_W'(pss_r) * TERM_W'(sy_r);
  end

  // stage 3: exact sum, round half up, saturate
  always_ff @(posedge clk) begin
    qx <= to_q15(SUM_W'(t_ccs_r) - SUM_W'(t_ssc_r));
    qy <= to_q15(SUM_W'(t_csc_r) + SUM_W'(t_scs_r));
    qz <= to_q15(SUM_W'(t_scc_r) - SUM_W'(t_css_r));
    qw <= to_q15(SUM_W'(t_ccc_r) + SUM_W'(t_sss_r));
  end

endmodule

// ===== sv/euler_to_quaternion_unit.sv =====
// channel  | strobe     | payload                                     | dir
// input    | start/busy | in_yaw_angle, in_pitch_angle, in_roll_angle | in
// result   | out_valid  | out_quat_x, out_quat_y, out_quat_z, out_quat_w | out
//
// Fully pipelined: one transfer per cycle while busy is low; each result passes
// through the CORDIC lanes (pre-rotation plus 28 steps) and then the merge
// stages (pair products, triple products, round/saturate).
// Synchronous active-low reset clears the valid pipeline; busy is high during
// reset and the cycle after, low otherwise. The receiver cannot stall.
module euler_to_quaternion_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [e2q_pkg::ANGLE_W-1:0]  in_yaw_angle,
  input  logic signed [e2q_pkg::ANGLE_W-1:0]  in_pitch_angle,
  input  logic signed [e2q_pkg::ANGLE_W-1:0]  in_roll_angle,
  output logic                                out_valid,
  output logic signed [e2q_pkg::QUAT_W-1:0]   out_quat_x,
  output logic signed [e2q_pkg::QUAT_W-1:0]   out_quat_y,
  output logic signed [e2q_pkg::QUAT_W-1:0]   out_quat_z,
  output logic signed [e2q_pkg::QUAT_W-1:0]   out_quat_w
);
  import e2q_pkg::*;

  logic                  busy_r;
  logic [TOTAL_LAT-1:0]  vld_r;
  logic                  accept;
  logic signed [TRIG_W-1:0] cy, sy, cp, sp, cr, sr;

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld_r  <= '0;
    end else begin
      busy_r <= 1'b0;
      vld_r  <= {vld_r[TOTAL_LAT-2:0], accept};
    end
  end

  assign out_valid = vld_r[TOTAL_LAT-1];

  // three lanes, one per axis, side by side
  e2q_cordic_lane u_yaw   (.clk(clk), .angle(in_yaw_angle),   .cos_half(cy), .sin_half(sy));
  e2q_cordic_lane u_pitch (.clk(clk), .angle(in_pitch_angle), .cos_half(cp), .sin_half(sp));
  e2q_cordic_lane u_roll  (.clk(clk), .angle(in_roll_angle),  .cos_half(cr), .sin_half(sr));

  e2q_merge u_merge (
    .clk (clk),
    .cy  (cy), .sy (sy), .cp (cp), .sp (sp), .cr (cr), .sr (sr),
    .qx  (out_quat_x), .qy (out_quat_y), .qz (out_quat_z), .qw (out_quat_w)
  );

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##TOTAL_LAT out_valid)
    else $error("accepted item produced no result");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, TOTAL_LAT))
    else $error("result without matching transfer");

  a_busy_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid)
    else $error("result while busy after reset");

endmodule

// ===== bench/euler_to_quaternion_unit_tb.sv =====
`timescale 1ns / 100ps

class quat_scoreboard;
  typedef struct {
    logic signed [15:0] qx, qy, qz, qw;
  } quat_t;

  quat_t pending_quats[$];
  int    mismatches;

  localparam longint HALF_PI_Z  = 421657428;
  localparam longint GAIN_INV   = 652032874;

  function void half_angle_trig(input logic signed [15:0] angle,
                                output longint c, output longint s);
    longint z, x, y, dx, dy;
    z = longint'(angle) * 16384;
    x = GAIN_INV;
    y = 0;
    if (z > HALF_PI_Z) begin
      x = 0; y = GAIN_INV; z -= HALF_PI_Z;
    end else if (z < -HALF_PI_Z) begin
      x = 0; y = -GAIN_INV; z += HALF_PI_Z;
    end
    for (int i = 0; i < 28; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_step(i);
      end else begin
        x += dx; y -= dy; z += arctan_step(i);
      end
    end
    c = x;
    s = y;
  endfunction

  function longint arctan_step(input int i);
    longint tab[10] = '{210828714, 124459457, 65760959, 33381290, 16755422,
                        8385879, 4193963, 2097109, 1048571, 524287};
    if (i < 10) return tab[i];
    return longint'(1) << (28 - i);
  endfunction

  function longint triple_q60(input longint a, input longint b, input longint c);
    longint ab;
    ab = (a * b) >>> 30;
    return ab * c;
  endfunction

  function logic signed [15:0] round_sat_q15(input longint sum);
    longint r;
    r = (sum + (longint'(1) << 44)) >>> 45;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function void note_angles(input logic signed [15:0] yaw, pitch, roll);
    longint cy, sy, cp, sp, cr, sr;
    quat_t q;
    half_angle_trig(yaw, cy, sy);
    half_angle_trig(pitch, cp, sp);
    half_angle_trig(roll, cr, sr);
    q.qx = round_sat_q15(triple_q60(cr, cp, sy) - triple_q60(sr, sp, cy));
    q.qy = round_sat_q15(triple_q60(cr, sp, cy) + triple_q60(sr, cp, sy));
    q.qz = round_sat_q15(triple_q60(sr, cp, cy) - triple_q60(cr, sp, sy));
    q.qw = round_sat_q15(triple_q60(cr, cp, cy) + triple_q60(sr, sp, sy));
    pending_quats.push_back(q);
  endfunction

  task report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  task check_quat(input logic signed [15:0] qx, qy, qz, qw);
    quat_t q;
    if (pending_quats.size() == 0) begin
      report("unexpected result", qx, 0);
      return;
    end
    q = pending_quats.pop_front();
    if (qx !== q.qx) report("quat_x", qx, q.qx);
    if (qy !== q.qy) report("quat_y", qy, q.qy);
    if (qz !== q.qz) report("quat_z", qz, q.qz);
    if (qw !== q.qw) report("quat_w", qw, q.qw);
  endtask
endclass

module euler_to_quaternion_unit_tb;
  import e2q_pkg::*;

  localparam int NUM_RANDOM  = 1000;
  localparam int STALL_LIMIT = 2000;   // idle cycles before the watchdog fires

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [ANGLE_W-1:0] in_yaw_angle, in_pitch_angle, in_roll_angle;
  logic out_valid;
  logic signed [QUAT_W-1:0] out_quat_x, out_quat_y, out_quat_z, out_quat_w;

  quat_scoreboard sb;
  int idle_cycles;
  bit burst_mode;   // no idling while set

  euler_to_quaternion_unit dut (
    .clk, .rst_n, .start, .busy,
    .in_yaw_angle, .in_pitch_angle, .in_roll_angle,
    .out_valid, .out_quat_x, .out_quat_y, .out_quat_z, .out_quat_w
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Results cannot be held off: check every strobed cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_quat(out_quat_x, out_quat_y, out_quat_z, out_quat_w);
  end

  // Watchdog on cycles with no transfer on either side.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // One input transfer. Random idle cycles ahead of it unless bursting.
  task send_angles(input logic signed [15:0] yaw, pitch, roll);
    while (!burst_mode && $urandom_range(99) < 31) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_yaw_angle   <= yaw;
    in_pitch_angle <= pitch;
    in_roll_angle  <= roll;
    do @(posedge clk); while (busy);
    sb.note_angles(yaw, pitch, roll);
  endtask

  // Mostly in range, with some raw words to toggle every bit.
  function logic signed [15:0] rand_angle();
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(51472)) - 25736);
  endfunction

  initial begin
    logic signed [15:0] edges[7] = '{-25736, 25736, 0, 12868, -12868, 32767, -32768};
    sb = new();
    rst_n          = 1'b0;
    start          = 1'b0;
    in_yaw_angle   = '0;
    in_pitch_angle = '0;
    in_roll_angle  = '0;
    burst_mode     = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: identity, range ends, quadrant boundaries, out-of-range words.
    foreach (edges[i]) send_angles(edges[i], 0, 0);
    foreach (edges[i]) send_angles(0, edges[i], 0);
    foreach (edges[i]) send_angles(0, 0, edges[i]);
    send_angles(25736, -25736, 25736);
    send_angles(-1, 1, -1);
    send_angles(6434, 6434, 6434);   // pi/4 on all axes

    for (int n = 0; n < NUM_RANDOM; n++) begin
      burst_mode = (n >= 400 && n < 550);
      send_angles(rand_angle(), rand_angle(), rand_angle());
    end
    start <= 1'b0;

    while (sb.pending_quats.size() != 0) @(posedge clk);
    repeat (TOTAL_LAT + 8) @(posedge clk);

    $display("covered %0d angle sets: range ends, quadrant edges, wrapped words, random",
             NUM_RANDOM + 24);
    $display("input idling at random plus a back-to-back stretch");
    if (sb.mismatches == 0 && sb.pending_quats.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// ===== euler_to_quaternion_unit.f =====
sv/e2q_pkg.sv
sv/e2q_cordic_lane.sv
sv/e2q_merge.sv
sv/euler_to_quaternion_unit.sv
bench/euler_to_quaternion_unit_tb.sv
